// ===== rtl/civdt_pkg.sv =====
package civdt_pkg;

  // Day offset (153*m+3)/5 of the March-based month m, indexed by the raw
  // month field. January and February map to months 13 and 14 of the
  // previous shifted year. Codes twelve to fifteen run on linearly.
  typedef logic [8:0] moff_t;

  localparam moff_t MONTH_OFFSET [16] = '{
    9'd398, 9'd429, 9'd92,  9'd123, 9'd153, 9'd184, 9'd214, 9'd245,
    9'd276, 9'd306, 9'd337, 9'd367, 9'd398, 9'd429, 9'd459, 9'd490
  };

  // floor(v / 25) for 0 <= v < 4200 is (v * 1311) >> 15.
  localparam int unsigned DIV25_MUL   = 1311;
  localparam int unsigned DIV25_SHIFT = 15;
  // Bias that keeps the quarter-year count positive, and its value / 25.
  localparam int unsigned Y4_BIAS     = 2100;
  localparam int unsigned Y100_BIAS   = Y4_BIAS / 25;
  localparam int unsigned DAY_EPOCH   = 11323;
  localparam int unsigned SEC_PER_DAY = 86400;

  typedef struct packed {
    logic signed [14:0] y;
    logic signed [10:0] yday;
    logic        [10:0] hm;
    logic        [5:0]  sec;
  } front_t;

  typedef struct packed {
    logic signed [12:0] y4;
    logic        [22:0] qprod;
    logic signed [22:0] y365;
    logic signed [10:0] yday;
    logic        [16:0] tod;
  } leap_t;

  typedef struct packed {
    logic signed [23:0] days;
    logic        [16:0] tod;
  } days_t;

  typedef struct packed {
    logic        [38:0] prod;
    logic        [16:0] tod;
  } scale_t;

endpackage

// ===== rtl/civdt_front.sv =====
module civdt_front (
  input  logic                clk,
  input  logic                en,
  input  logic signed [13:0]  year_since_1900,
  input  logic [3:0]          month_index,
  input  logic [4:0]          day_of_month,
  input  logic signed [9:0]   day_of_year,
  input  logic [4:0]          hour,
  input  logic [5:0]          minute,
  input  logic [5:0]          second,
  output civdt_pkg::front_t   front_r
);
  import civdt_pkg::*;

  front_t             front_nxt;
  logic               month_mode;
  logic               dec;
  logic signed [10:0] yday_mon;

  always_comb begin
    month_mode = day_of_year[9];
    // January and February belong to the previous shifted year; the
    // day-of-year form counts from January 1 and always takes the previous shifted year.
    dec = month_mode ? (month_index <= 4'd1) : 1'b1;
    yday_mon = $signed({2'b00, MONTH_OFFSET[month_index]})
             + $signed({6'd0, day_of_month}) - 11'sd399;
    front_nxt.y = $signed({year_since_1900[13], year_since_1900}) - 15'sd100
                - $signed({14'd0, dec});
    front_nxt.yday = month_mode ? yday_mon
                                : $signed({day_of_year[9], day_of_year});
    front_nxt.hm = ({6'd0, hour} * 11'd60) + {5'd0, minute};
    front_nxt.sec = second;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

endmodule

// ===== rtl/civdt_leap.sv =====
module civdt_leap (
  input  logic               clk,
  input  logic               en,
  input  civdt_pkg::front_t  front_r,
  output civdt_pkg::days_t   days_r
);
  import civdt_pkg::*;

  leap_t              leap_r;
  leap_t              leap_nxt;
  days_t              days_nxt;
  logic signed [14:0] y4_wide;
  logic signed [13:0] y4_biased;
  logic signed [22:0] y_ext;
  logic        [7:0]  q;
  logic signed [8:0]  y100;
  logic signed [8:0]  y400;

  // First stage: floor(y/4), the biased product for the divide by 25,
  // 365 * y, and the time of day in seconds.
  always_comb begin
    y4_wide = front_r.y >>> 2;
    leap_nxt.y4 = y4_wide[12:0];
    y4_biased = $signed({leap_nxt.y4[12], leap_nxt.y4}) + 14'(Y4_BIAS);
    leap_nxt.qprod = {10'd0, y4_biased[12:0]} * 23'(DIV25_MUL);
    y_ext = {{8{front_r.y[14]}}, front_r.y};
    leap_nxt.y365 = y_ext * 23'sd365;
    leap_nxt.yday = front_r.yday;
    leap_nxt.tod = ({6'd0, front_r.hm} * 17'd60) + {11'd0, front_r.sec};
  end

  // Second stage: remove the bias, then sum up the day count.
  always_comb begin
    q = leap_r.qprod[DIV25_SHIFT +: 8];
    y100 = $signed({1'b0, q}) - 9'(Y100_BIAS);
    y400 = y100 >>> 2;
    days_nxt.days = {{1{leap_r.y365[22]}}, leap_r.y365}
                  + {{11{leap_r.y4[12]}}, leap_r.y4}
                  + {{13{leap_r.yday[10]}}, leap_r.yday}
                  + 24'(DAY_EPOCH)
                  - {{15{y100[8]}}, y100}
                  + {{15{y400[8]}}, y400};
    days_nxt.tod = leap_r.tod;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      leap_r <= leap_nxt;
      days_r <= days_nxt;
    end
  end

endmodule

// ===== rtl/civdt_scale.sv =====
module civdt_scale (
  input  logic              clk,
  input  logic              en,
  input  civdt_pkg::days_t  days_r,
  output logic [38:0]       secs_r
);
  import civdt_pkg::*;

  scale_t             scale_r;
  scale_t             scale_nxt;
  logic signed [40:0] prod_full;
  logic [38:0]        secs_nxt;

  always_comb begin
    prod_full = $signed({{17{days_r.days[23]}}, days_r.days}) * 41'(SEC_PER_DAY);
    scale_nxt.prod = prod_full[38:0];
    scale_nxt.tod = days_r.tod;
    // The sum wraps to 39 bits in two's complement.
    secs_nxt = scale_r.prod + {22'd0, scale_r.tod};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scale_r <= scale_nxt;
      secs_r  <= secs_nxt;
    end
  end

endmodule

// ===== rtl/civil_datetime_to_unix_seconds_top.sv =====
// Civil date-time to Unix seconds converter.
//
// The input channel (in_valid / in_ready) carries one UTC date-time per
// beat: year minus 1900, month, day of month, zero-based day of year,
// hour, minute and second. A negative day of year selects the month and
// day form; otherwise the day of year is used as given. The result channel
// (out_valid / out_ready) returns one beat per input beat, in order: the
// signed 39-bit count of seconds since 1970-01-01 00:00:00 UTC.
//
// The datapath is a five-stage pipeline: field preparation, leap-year
// quotients and 365*y, day count sum, day-to-seconds multiply, and the
// final add of the time of day. A result is presented on the output once
// its input beat has passed through all the stages, and one beat is
// accepted every cycle while the output is not stalled.
//
// When the receiver stalls, the whole pipeline holds: in_ready drops as
// soon as the output stage holds a beat that is not taken, and no beat is
// lost or repeated. Reset clears the stage valid bits only; the data
// registers need no reset since nothing is stored between beats.
module civil_datetime_to_unix_seconds_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] in_year_since_1900,
  input  logic [3:0]         in_month_index,
  input  logic [4:0]         in_day_of_month,
  input  logic signed [9:0]  in_day_of_year,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [38:0] out_unix_seconds
);
  import civdt_pkg::*;

  localparam int STAGES = 5;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic              en;
  front_t            front_r;
  days_t             days_r;
  logic [38:0]       secs_r;

  // The pipeline advances as a whole unless the output beat is waiting.
  assign en = ~valid_r[STAGES-1] | out_ready;
  assign in_ready = en;
  assign out_valid = valid_r[STAGES-1];
  assign out_unix_seconds = $signed(secs_r);

  always_comb begin
    valid_nxt = valid_r;
    if (en) begin
      valid_nxt = {valid_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  civdt_front u_front (
    .clk             (clk),
    .en              (en),
    .year_since_1900 (in_year_since_1900),
    .month_index     (in_month_index),
    .day_of_month    (in_day_of_month),
    .day_of_year     (in_day_of_year),
    .hour            (in_hour),
    .minute          (in_minute),
    .second          (in_second),
    .front_r         (front_r)
  );

  civdt_leap u_leap (
    .clk     (clk),
    .en      (en),
    .front_r (front_r),
    .days_r  (days_r)
  );

  civdt_scale u_scale (
    .clk    (clk),
    .en     (en),
    .days_r (days_r),
    .secs_r (secs_r)
  );

endmodule
